### sv/grdz_pkg.sv
// Shared widths, register codes, sample side-band type and helpers for the radial deadzone unit.
`timescale 1ns / 1ps

package grdz_pkg;

  localparam int OUT_FRAC_BITS_DEF = 15;

  localparam int AXIS_W     = 16;
  localparam int TRIG_W     = 8;
  localparam int BTN_W      = 16;
  localparam int DZ_W       = 15;
  localparam int M2_W       = 32;
  localparam int LQ_W       = 24;
  localparam int P_W        = AXIS_W + LQ_W;
  localparam int DEN_W      = LQ_W + DZ_W;
  localparam int OUT_TRIG_W = 15;
  localparam int IN_W       = 96;
  localparam int OUT_W      = 112;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [DZ_W-1:0]   DZ_MAX       = 15'd32766;
  localparam logic [DZ_W-1:0]   FULL_SCALE   = 15'd32767;
  localparam logic [DZ_W-1:0]   LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RST = 15'd8689;
  localparam logic [TRIG_W-1:0] TRIG_FULL    = 8'd255;
  localparam logic [TRIG_W-1:0] TRIG_TH_RST  = 8'd30;

  typedef enum logic [1:0] {
    REG_LEFT_DZ  = 2'd0,
    REG_RIGHT_DZ = 2'd1,
    REG_TRIG_TH  = 2'd2
  } grdz_reg_t;

  // Per-sample data that rides along the pipeline beside the arithmetic.
  // Index 0 is the left stick, index 1 the right stick.
  typedef struct packed {
    logic [1:0][AXIS_W-1:0] ax;
    logic [1:0][AXIS_W-1:0] ay;
    logic [1:0]             nx;
    logic [1:0]             ny;
    logic [1:0]             dead;
    logic [1:0][DZ_W-1:0]   dz;
    logic [TRIG_W-1:0]      tl;
    logic [TRIG_W-1:0]      tr;
    logic [TRIG_W-1:0]      th;
    logic [BTN_W-1:0]       btn;
  } grdz_side_t;

  function automatic logic [AXIS_W-1:0] axis_mag(input logic [AXIS_W-1:0] raw);
    return raw[AXIS_W-1] ? (~raw + 1'b1) : raw;
  endfunction

  function automatic logic [DZ_W-1:0] dz_clamp(input logic [DZ_W-1:0] dz);
    return (dz > DZ_MAX) ? DZ_MAX : dz;
  endfunction

endpackage

### sv/grdz_isqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
`timescale 1ns / 1ps

module grdz_isqrt #(
  parameter int RW = grdz_pkg::LQ_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] v_i,
  output logic [RW-1:0]   root_o
);

  localparam int REMW = RW + 2;
  localparam int TW   = RW + 4;

  logic [REMW-1:0] rem_r  [RW-1];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] v_r    [RW-1];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [REMW-1:0] rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] v_prev;
    logic [TW-1:0]   acc;
    logic [TW-1:0]   trial;
    logic            fit;
    logic [REMW-1:0] rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (i == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign v_prev    = v_i;
    end else begin : g_next
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
      assign v_prev    = v_r[i-1];
    end

    always_comb begin
      acc      = {rem_prev, v_prev[2*RW-1 -: 2]};
      trial    = TW'({root_prev, 2'b01});
      fit      = (acc >= trial);
      rem_nxt  = fit ? REMW'(acc - trial) : REMW'(acc);
      root_nxt = {root_prev[RW-2:0], fit};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= root_nxt;
      end
    end

    if (i < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          v_r[i]   <= {v_prev[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

### sv/grdz_div.sv
// Pipelined restoring divider with saturation: operand register, then one quotient bit per stage.
`timescale 1ns / 1ps

module grdz_div #(
  parameter int NW = 57,
  parameter int DW = 40,
  parameter int QB = grdz_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] q_o
);

  localparam int RMW = DW + QB;
  localparam int CW  = (NW > RMW) ? NW : RMW;

  logic          ovf_r [QB+1];
  logic [RMW-1:0] rem_r [QB];
  logic [DW-1:0]  d_r   [QB];
  logic [QB-1:0]  q_r   [QB];

  logic ovf_nxt;

  // A quotient that does not fit in QB bits saturates to all ones.
  always_comb begin
    ovf_nxt = (CW'(num_i) >= (CW'(den_i) << QB));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= ovf_nxt;
      rem_r[0] <= RMW'(num_i);
      d_r[0]   <= den_i;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int K = QB - j;
    logic [RMW-1:0] trial;
    logic           fit;
    logic [QB-1:0]  q_prev;
    logic [QB-1:0]  q_nxt;

    if (j == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_next
      assign q_prev = q_r[j-2];
    end

    always_comb begin
      trial = RMW'(d_r[j-1]) << K;
      fit   = (rem_r[j-1] >= trial);
      q_nxt = q_prev | (QB'(fit) << K);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j-1] <= q_nxt;
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= fit ? (rem_r[j-1] - trial) : rem_r[j-1];
          d_r[j]   <= d_r[j-1];
        end
      end
    end
  end

  assign q_o = ovf_r[QB] ? '1 : q_r[QB-1];

endmodule

### sv/gamepad_radial_deadzone_scaler_unit.sv
// Top level of the scaled radial deadzone unit: config registers, pipeline and output stage.
`timescale 1ns / 1ps
// Throughput: one sample per cycle unless the output stalls; the figure is set by the
// 24-stage square-root pipeline and the OUT_FRAC_BITS + 1 stage dividers, each of which
// takes a new operand every cycle that it is enabled.
// A stalled output freezes the whole pipeline in place, so nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) clears every valid bit and loads the register defaults.

module gamepad_radial_deadzone_scaler_unit #(
  parameter int OUT_FRAC_BITS = grdz_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // in_tdata from bit 0: left_stick_x, left_stick_y, right_stick_x, right_stick_y,
  // left_trigger_raw, right_trigger_raw, button_bits.
  input  logic [grdz_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_tdata from bit 0: left_x_scaled, left_y_scaled, right_x_scaled, right_y_scaled,
  // left_trigger_scaled, right_trigger_scaled, button_bits_out, two zero pad bits.
  output logic [grdz_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [grdz_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [grdz_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [grdz_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int F      = OUT_FRAC_BITS;
  localparam int AW     = grdz_pkg::AXIS_W;
  localparam int TW     = grdz_pkg::TRIG_W;
  localparam int DZW    = grdz_pkg::DZ_W;
  localparam int LQW    = grdz_pkg::LQ_W;
  localparam int VW     = 2 * LQW;
  localparam int SQ_LAT = LQW;
  localparam int NW_S   = grdz_pkg::P_W + F + 2;
  localparam int DW_S   = grdz_pkg::DEN_W + 1;
  localparam int NW_T   = TW + F + 2;
  localparam int DW_T   = TW + 1;
  localparam logic [F-1:0] LIM = '1;

  // ---------------------------------------------------------------------------------------
  // Configuration registers at byte addresses 0, 4 and 8; address bits 1:0 are not decoded
  // and writes to 12-15 are ignored. Reads return the register value with zeros above it.
  // ---------------------------------------------------------------------------------------
  logic [DZW-1:0] ldz_r;
  logic [DZW-1:0] rdz_r;
  logic [TW-1:0]  th_r;
  logic           cfg_wr;
  grdz_pkg::grdz_reg_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = grdz_pkg::grdz_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldz_r <= grdz_pkg::LEFT_DZ_RST;
      rdz_r <= grdz_pkg::RIGHT_DZ_RST;
      th_r  <= grdz_pkg::TRIG_TH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        grdz_pkg::REG_LEFT_DZ: begin
          ldz_r <= cfg_pwdata[DZW-1:0];
        end
        grdz_pkg::REG_RIGHT_DZ: begin
          rdz_r <= cfg_pwdata[DZW-1:0];
        end
        grdz_pkg::REG_TRIG_TH: begin
          th_r <= cfg_pwdata[TW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      grdz_pkg::REG_LEFT_DZ:  cfg_prdata = grdz_pkg::CFG_DW'(ldz_r);
      grdz_pkg::REG_RIGHT_DZ: cfg_prdata = grdz_pkg::CFG_DW'(rdz_r);
      grdz_pkg::REG_TRIG_TH:  cfg_prdata = grdz_pkg::CFG_DW'(th_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. Every stage advances together whenever the output register is empty
  // or its transaction completes; in_tready is that same enable, so no sample is taken while
  // a result waits, even if the pipeline holds empty stages.
  // ---------------------------------------------------------------------------------------
  logic pipe_en;
  logic out_valid_r;

  assign pipe_en    = !out_valid_r || out_tready;
  assign in_tready  = pipe_en;
  assign out_tvalid = out_valid_r;

  // Stage 1: unpack the sample, take axis magnitudes and signs, clamp the deadzones.
  grdz_pkg::grdz_side_t sd1_nxt;
  grdz_pkg::grdz_side_t sd1_r;
  logic                 vld1_r;

  always_comb begin
    sd1_nxt       = '0;
    sd1_nxt.ax[0] = grdz_pkg::axis_mag(in_tdata[15:0]);
    sd1_nxt.ay[0] = grdz_pkg::axis_mag(in_tdata[31:16]);
    sd1_nxt.ax[1] = grdz_pkg::axis_mag(in_tdata[47:32]);
    sd1_nxt.ay[1] = grdz_pkg::axis_mag(in_tdata[63:48]);
    sd1_nxt.nx    = {in_tdata[47], in_tdata[15]};
    sd1_nxt.ny    = {in_tdata[63], in_tdata[31]};
    sd1_nxt.dz[0] = grdz_pkg::dz_clamp(ldz_r);
    sd1_nxt.dz[1] = grdz_pkg::dz_clamp(rdz_r);
    sd1_nxt.tl    = in_tdata[71:64];
    sd1_nxt.tr    = in_tdata[79:72];
    sd1_nxt.th    = th_r;
    sd1_nxt.btn   = in_tdata[95:80];
  end

  // Stage 2: squares of both axes and of the deadzone radius.
  grdz_pkg::grdz_side_t sd2_r;
  logic                 vld2_r;
  logic [grdz_pkg::M2_W-1:0] ax2_r [2];
  logic [grdz_pkg::M2_W-1:0] ay2_r [2];
  logic [2*DZW-1:0]          dz2_r [2];

  // Stage 3: squared length, deadzone test and the scaled radicand for the root.
  grdz_pkg::grdz_side_t sd3_nxt;
  grdz_pkg::grdz_side_t sd3_r;
  logic                 vld3_r;
  logic [VW-1:0]        v3_r [2];
  logic [grdz_pkg::M2_W-1:0] m2_nxt [2];

  always_comb begin
    sd3_nxt = sd2_r;
    for (int s = 0; s < 2; s++) begin
      m2_nxt[s]       = ax2_r[s] + ay2_r[s];
      sd3_nxt.dead[s] = (m2_nxt[s] <= grdz_pkg::M2_W'(dz2_r[s]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (pipe_en) begin
      vld1_r <= in_tvalid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sd1_r <= sd1_nxt;
      sd2_r <= sd1_r;
      for (int s = 0; s < 2; s++) begin
        ax2_r[s] <= grdz_pkg::M2_W'(sd1_r.ax[s] * sd1_r.ax[s]);
        ay2_r[s] <= grdz_pkg::M2_W'(sd1_r.ay[s] * sd1_r.ay[s]);
        dz2_r[s] <= (2*DZW)'(sd1_r.dz[s] * sd1_r.dz[s]);
      end
      sd3_r <= sd3_nxt;
      for (int s = 0; s < 2; s++) begin
        v3_r[s] <= VW'(m2_nxt[s]) << 16;
      end
    end
  end

  // Square root: the length with eight fraction bits, one result bit per stage. The side
  // band follows through a delay line of the same depth.
  logic [LQW-1:0]       lq [2];
  grdz_pkg::grdz_side_t sq_sd_r  [SQ_LAT];
  logic                 sq_vld_r [SQ_LAT];

  for (genvar s = 0; s < 2; s++) begin : g_sqrt
    grdz_isqrt #(
      .RW(LQW)
    ) u_isqrt (
      .clk   (clk),
      .en    (pipe_en),
      .v_i   (v3_r[s]),
      .root_o(lq[s])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_LAT; i++) begin
        sq_vld_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      sq_vld_r[0] <= vld3_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        sq_vld_r[i] <= sq_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_sd_r[0] <= sd3_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        sq_sd_r[i] <= sq_sd_r[i-1];
      end
    end
  end

  // Stage M1: length beyond the deadzone and the remaining span of travel.
  // Stage M2: the three products per stick.
  // Stage M3: numerators and divisors with the half-divisor added for rounding.
  grdz_pkg::grdz_side_t m1_sd_r;
  grdz_pkg::grdz_side_t m2_sd_r;
  grdz_pkg::grdz_side_t m3_sd_r;
  logic                 m1_vld_r;
  logic                 m2_vld_r;
  logic                 m3_vld_r;

  logic [LQW-1:0]            lq1_r  [2];
  logic [LQW-1:0]            exc1_r [2];
  logic [DZW-1:0]            cdz1_r [2];
  logic [grdz_pkg::DEN_W-1:0] den2_r [2];
  logic [grdz_pkg::P_W-1:0]  px2_r  [2];
  logic [grdz_pkg::P_W-1:0]  py2_r  [2];
  logic [NW_S-1:0]           numx3_r [2];
  logic [NW_S-1:0]           numy3_r [2];
  logic [DW_S-1:0]           dd3_r   [2];
  logic [NW_T-1:0]           numt3_r [2];
  logic [DW_T-1:0]           dt3_r;
  logic [LQW-1:0]            dzs    [2];
  logic [TW-1:0]             tspan;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      dzs[s] = LQW'({sq_sd_r[SQ_LAT-1].dz[s], 8'b0});
    end
    tspan = grdz_pkg::TRIG_FULL - m2_sd_r.th;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m1_vld_r <= sq_vld_r[SQ_LAT-1];
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_sd_r <= sq_sd_r[SQ_LAT-1];
      m2_sd_r <= m1_sd_r;
      m3_sd_r <= m2_sd_r;
      for (int s = 0; s < 2; s++) begin
        lq1_r[s]  <= lq[s];
        exc1_r[s] <= (lq[s] > dzs[s]) ? (lq[s] - dzs[s]) : '0;
        cdz1_r[s] <= grdz_pkg::FULL_SCALE - sq_sd_r[SQ_LAT-1].dz[s];
        den2_r[s] <= grdz_pkg::DEN_W'(lq1_r[s] * cdz1_r[s]);
        px2_r[s]  <= grdz_pkg::P_W'(m1_sd_r.ax[s] * exc1_r[s]);
        py2_r[s]  <= grdz_pkg::P_W'(m1_sd_r.ay[s] * exc1_r[s]);
        numx3_r[s] <= (NW_S'(px2_r[s]) << (F + 1)) + NW_S'(den2_r[s]);
        numy3_r[s] <= (NW_S'(py2_r[s]) << (F + 1)) + NW_S'(den2_r[s]);
        dd3_r[s]   <= {den2_r[s], 1'b0};
      end
      numt3_r[0] <= (NW_T'(TW'(m2_sd_r.tl - m2_sd_r.th)) << (F + 1)) + NW_T'(tspan);
      numt3_r[1] <= (NW_T'(TW'(m2_sd_r.tr - m2_sd_r.th)) << (F + 1)) + NW_T'(tspan);
      dt3_r      <= {tspan, 1'b0};
    end
  end

  // Dividers: one per stick axis and one per trigger, all of the same depth.
  logic [F-1:0] qx [2];
  logic [F-1:0] qy [2];
  logic [F-1:0] qt [2];

  for (genvar s = 0; s < 2; s++) begin : g_div
    grdz_div #(
      .NW(NW_S),
      .DW(DW_S),
      .QB(F)
    ) u_div_x (
      .clk  (clk),
      .en   (pipe_en),
      .num_i(numx3_r[s]),
      .den_i(dd3_r[s]),
      .q_o  (qx[s])
    );

    grdz_div #(
      .NW(NW_S),
      .DW(DW_S),
      .QB(F)
    ) u_div_y (
      .clk  (clk),
      .en   (pipe_en),
      .num_i(numy3_r[s]),
      .den_i(dd3_r[s]),
      .q_o  (qy[s])
    );

    grdz_div #(
      .NW(NW_T),
      .DW(DW_T),
      .QB(F)
    ) u_div_t (
      .clk  (clk),
      .en   (pipe_en),
      .num_i(numt3_r[s]),
      .den_i(dt3_r),
      .q_o  (qt[s])
    );
  end

  grdz_pkg::grdz_side_t dv_sd_r  [F+1];
  logic                 dv_vld_r [F+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= F; i++) begin
        dv_vld_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      dv_vld_r[0] <= m3_vld_r;
      for (int i = 1; i <= F; i++) begin
        dv_vld_r[i] <= dv_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_sd_r[0] <= m3_sd_r;
      for (int i = 1; i <= F; i++) begin
        dv_sd_r[i] <= dv_sd_r[i-1];
      end
    end
  end

  // Output stage: apply the deadzone and threshold, restore signs (Y inverted) and pack.
  grdz_pkg::grdz_side_t        fin;
  logic [AW-1:0]               ox_nxt [2];
  logic [AW-1:0]               oy_nxt [2];
  logic [grdz_pkg::OUT_TRIG_W-1:0] ot_nxt [2];
  logic [grdz_pkg::OUT_W-1:0]  out_data_r;

  assign fin = dv_sd_r[F];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      if (fin.dead[s]) begin
        ox_nxt[s] = '0;
        oy_nxt[s] = '0;
      end else begin
        ox_nxt[s] = fin.nx[s] ? -AW'(qx[s]) : AW'(qx[s]);
        oy_nxt[s] = fin.ny[s] ? AW'(qy[s]) : -AW'(qy[s]);
      end
    end
    ot_nxt[0] = (fin.tl <= fin.th) ? '0 : grdz_pkg::OUT_TRIG_W'(qt[0]);
    ot_nxt[1] = (fin.tr <= fin.th) ? '0 : grdz_pkg::OUT_TRIG_W'(qt[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= dv_vld_r[F];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= {2'b00, fin.btn, ot_nxt[1], ot_nxt[0],
                     oy_nxt[1], ox_nxt[1], oy_nxt[0], ox_nxt[0]};
    end
  end

  assign out_tdata = out_data_r;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // A stall freezes the valid bits at stage 3, the square root, the dividers and the output.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld3_r) && $stable(sq_vld_r[SQ_LAT-1]) &&
                 $stable(dv_vld_r[F]) && $stable(out_valid_r))
    else $error("pipeline moved during a stall");

  // Saturation keeps stick axes away from the most negative code.
  a_stick_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tdata[15:0] != 16'h8000) && (out_tdata[31:16] != 16'h8000) &&
                    (out_tdata[47:32] != 16'h8000) && (out_tdata[63:48] != 16'h8000))
    else $error("stick axis outside the saturated range");

  // Trigger results never exceed the saturation limit.
  a_trig_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tdata[78:64] <= grdz_pkg::OUT_TRIG_W'(LIM)) &&
                    (out_tdata[93:79] <= grdz_pkg::OUT_TRIG_W'(LIM)))
    else $error("trigger result above the saturation limit");

  // A left stick inside its deadzone gives zero on both axes.
  a_dead_left: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && dv_vld_r[F] && fin.dead[0] |=> out_tdata[31:0] == 32'd0)
    else $error("left stick inside deadzone produced a nonzero result");

  // A left trigger at or below the threshold reads zero.
  a_trig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && dv_vld_r[F] && (fin.tl <= fin.th) |=> out_tdata[78:64] == 15'd0)
    else $error("left trigger at or below threshold produced a nonzero result");

endmodule

### dv/tb_gamepad_radial_deadzone_scaler_unit.sv
// Self-checking testbench for the scaled radial deadzone unit with its own arithmetic predictor.
`timescale 1ns / 1ps

module tb_gamepad_radial_deadzone_scaler_unit;

  localparam int FRAC = 15;
  // The drain pause outlasts the block's latency at the default OUT_FRAC_BITS.
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [15:0] btn;
    logic [7:0]  tr;
    logic [7:0]  tl;
    logic [15:0] ry;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] lx;
  } sample_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] btn;
    logic [14:0] tr;
    logic [14:0] tl;
    logic [15:0] ry;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] lx;
  } shaped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [grdz_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [grdz_pkg::OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [grdz_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [grdz_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [grdz_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  // Predictor's copy of the configuration registers.
  logic [14:0] left_dz_q = grdz_pkg::LEFT_DZ_RST;
  logic [14:0] right_dz_q = grdz_pkg::RIGHT_DZ_RST;
  logic [7:0]  trig_th_q = grdz_pkg::TRIG_TH_RST;

  shaped_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always #1 clk = ~clk;

  gamepad_radial_deadzone_scaler_unit dut (.*);

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Shapes one stick pair; the Y axis comes out negated.
  function automatic void shape_stick(input logic [15:0] rx, input logic [15:0] ry,
                                      input logic [14:0] dzr, output logic [15:0] ox,
                                      output logic [15:0] oy);
    logic [63:0] ax, ay, dz, m2, lq, excess, den, mx, my, lim;
    logic nx, ny;
    nx = rx[15];
    ny = ry[15];
    ax = nx ? 64'h10000 - 64'(rx) : 64'(rx);
    ay = ny ? 64'h10000 - 64'(ry) : 64'(ry);
    dz = (dzr > grdz_pkg::DZ_MAX) ? 64'(grdz_pkg::DZ_MAX) : 64'(dzr);
    lim = (64'd1 << FRAC) - 1;
    m2 = ax * ax + ay * ay;
    ox = '0;
    oy = '0;
    if (m2 > dz * dz) begin
      lq = int_sqrt(m2 << 16);
      excess = (lq > (dz << 8)) ? lq - (dz << 8) : 64'd0;
      den = lq * (64'd32767 - dz);
      mx = (((ax * excess) << FRAC) * 2 + den) / (2 * den);
      my = (((ay * excess) << FRAC) * 2 + den) / (2 * den);
      if (mx > lim) mx = lim;
      if (my > lim) my = lim;
      // A zero magnitude never turns into a negative code.
      if (mx != 0) ox = nx ? 16'(17'h10000 - mx) : mx[15:0];
      if (my != 0) oy = !ny ? 16'(17'h10000 - my) : my[15:0];
    end
  endfunction

  function automatic logic [14:0] shape_trigger(input logic [7:0] t, input logic [7:0] th);
    logic [63:0] den, q;
    if (t <= th) return '0;
    den = 64'(8'd255 - th);
    q = ((64'(t - th) << FRAC) * 2 + den) / (2 * den);
    if (q > 32767) q = 32767;
    return q[14:0];
  endfunction

  function automatic shaped_t shape_sample(input sample_t s);
    shaped_t r;
    r.pad = '0;
    shape_stick(s.lx, s.ly, left_dz_q, r.lx, r.ly);
    shape_stick(s.rx, s.ry, right_dz_q, r.rx, r.ry);
    r.tl = shape_trigger(s.tl, trig_th_q);
    r.tr = shape_trigger(s.tr, trig_th_q);
    r.btn = s.btn;
    return r;
  endfunction

  // Result checker on the sampled rising edge; the receiver stall generator below uses the falling edge.
  always @(posedge clk) begin
    shaped_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.lx !== want.lx) begin
          $display("%0t: left_x exp %h got %h", $time, want.lx, got.lx); errors++;
        end
        if (got.ly !== want.ly) begin
          $display("%0t: left_y exp %h got %h", $time, want.ly, got.ly); errors++;
        end
        if (got.rx !== want.rx) begin
          $display("%0t: right_x exp %h got %h", $time, want.rx, got.rx); errors++;
        end
        if (got.ry !== want.ry) begin
          $display("%0t: right_y exp %h got %h", $time, want.ry, got.ry); errors++;
        end
        if (got.tl !== want.tl) begin
          $display("%0t: left_trig exp %h got %h", $time, want.tl, got.tl); errors++;
        end
        if (got.tr !== want.tr) begin
          $display("%0t: right_trig exp %h got %h", $time, want.tr, got.tr); errors++;
        end
        if (got.btn !== want.btn) begin
          $display("%0t: buttons exp %h got %h", $time, want.btn, got.btn); errors++;
        end
        if (got.pad !== want.pad) begin
          $display("%0t: pad exp %h got %h", $time, want.pad, got.pad); errors++;
        end
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Sends one sample as one input transaction and records its expected result. Valid stays
  // high after a transaction so that samples can follow back to back.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(shape_sample(s));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes one register through the config port; set_config calls it once the pipeline is drained.
  task automatic write_reg(input grdz_pkg::grdz_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= grdz_pkg::CFG_AW'(4 * int'(idx)); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      grdz_pkg::REG_LEFT_DZ:  left_dz_q = val[14:0];
      grdz_pkg::REG_RIGHT_DZ: right_dz_q = val[14:0];
      default:                trig_th_q = val[7:0];
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [14:0] ldz, input logic [14:0] rdz,
                            input logic [7:0] th);
    wait_drained();
    write_reg(grdz_pkg::REG_LEFT_DZ, 32'(ldz));
    write_reg(grdz_pkg::REG_RIGHT_DZ, 32'(rdz));
    write_reg(grdz_pkg::REG_TRIG_TH, 32'(th));
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'($urandom_range(1) ? 16'h8000 : 16'h7FFF);
      1: return 16'($signed($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.lx = rand_axis(); s.ly = rand_axis();
    s.rx = rand_axis(); s.ry = rand_axis();
    s.tl = $urandom_range(3) == 0 ? 8'(trig_th_q + $urandom_range(1)) : 8'($urandom);
    s.tr = 8'($urandom);
    s.btn = 16'($urandom);
    return s;
  endfunction

  // Extremes of every field, deadzone edges and saturation at the corners.
  task automatic test_directed();
    sample_t s;
    s = '{btn: 16'h0000, tr: 8'd0, tl: 8'd0, ry: 16'h0000, rx: 16'h0000,
          ly: 16'h0000, lx: 16'h0000};
    send_sample(s);
    s = '{btn: 16'hFFFF, tr: 8'd255, tl: 8'd255, ry: 16'h8000, rx: 16'h8000,
          ly: 16'h8000, lx: 16'h8000};
    send_sample(s);
    s = '{btn: 16'hA5A5, tr: 8'd30, tl: 8'd31, ry: 16'h7FFF, rx: 16'h7FFF,
          ly: 16'h7FFF, lx: 16'h7FFF};
    send_sample(s);
    // Right on the deadzone radius, and one step outside it.
    s = '{btn: 16'h5A5A, tr: 8'd29, tl: 8'd1, ry: 16'd0, rx: 16'd8689,
          ly: 16'd7849, lx: 16'd0};
    send_sample(s);
    s = '{btn: 16'h0001, tr: 8'd254, tl: 8'd128, ry: 16'd0, rx: 16'd8690,
          ly: -16'sd7850, lx: 16'd0};
    send_sample(s);
    s = '{btn: 16'h8000, tr: 8'd200, tl: 8'd100, ry: 16'h0001, rx: 16'h8000,
          ly: 16'h7FFF, lx: 16'hFFFF};
    send_sample(s);
    // Zero left deadzone, right at its maximum: tiny left deflections pass; max threshold silences triggers.
    set_config(15'd0, 15'd32767, 8'd255);
    s = '{btn: 16'h1234, tr: 8'd255, tl: 8'd255, ry: 16'h7FFF, rx: 16'h8000,
          ly: 16'hFFFF, lx: 16'h0001};
    send_sample(s);
    s = '{btn: 16'h4321, tr: 8'd0, tl: 8'd254, ry: 16'h8000, rx: 16'h8000,
          ly: 16'h0000, lx: 16'hFFFF};
    send_sample(s);
    set_config(15'd32766, 15'd0, 8'd0);
    s = '{btn: 16'hFFFF, tr: 8'd1, tl: 8'd0, ry: 16'hFFFF, rx: 16'h0001,
          ly: 16'h8000, lx: 16'h8000};
    send_sample(s);
    s = '{btn: 16'h0F0F, tr: 8'd255, tl: 8'd128, ry: 16'h7FFF, rx: 16'h7FFF,
          ly: 16'h7FFF, lx: 16'h7FFF};
    send_sample(s);
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      send_sample(rand_sample());
      // With no send idling, let the pipeline run dry once mid-stream.
      if (i == count / 2 && s_idle == 0) begin
        in_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    set_config(15'($urandom_range(32767)), 15'($urandom_range(32767)), 8'($urandom));
    test_random(360, 11, 47);
    set_config(15'd7849, 15'd8689, 8'd30);
    test_random(360, 47, 11);
    set_config(15'($urandom_range(12000)), 15'($urandom_range(12000)), 8'($urandom));
    test_random(360, 0, 0);
    wait_drained();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
sv/grdz_pkg.sv
sv/grdz_isqrt.sv
sv/grdz_div.sv
sv/gamepad_radial_deadzone_scaler_unit.sv
dv/tb_gamepad_radial_deadzone_scaler_unit.sv
